/* hdl/ncu_pkg.sv */
// ----------------------------------------------------------------------------
// ncu_pkg
// Types, codes and constants shared by the network coordinate update unit.
// ----------------------------------------------------------------------------
package ncu_pkg;

	localparam logic [16:0] ONE_Q16 = 17'd65536;

	localparam logic signed [39:0] COORD_MAX = {1'b0, {39{1'b1}}};
	localparam logic signed [39:0] COORD_MIN = {1'b1, {39{1'b0}}};

	// iteration counts of the shared arithmetic unit
	localparam logic [5:0] K_Q16  = 6'd17;
	localparam logic [5:0] K_UNIT = 6'd21;
	localparam logic [5:0] K_RE   = 6'd24;
	localparam logic [5:0] K_SQRT = 6'd41;

	localparam logic [1:0] STS_UPDATED = 2'd0;
	localparam logic [1:0] STS_REJECT  = 2'd1;
	localparam logic [1:0] STS_RESTART = 2'd2;

	localparam logic [2:0] CFG_ERROR_GAIN    = 3'd0;
	localparam logic [2:0] CFG_MOVE_FRACTION = 3'd1;
	localparam logic [2:0] CFG_TOLERANCE     = 3'd2;
	localparam logic [2:0] CFG_DEFAULT_ERROR = 3'd3;
	localparam logic [2:0] CFG_START_X       = 3'd4;
	localparam logic [2:0] CFG_START_Y       = 3'd5;

	typedef enum logic [1:0] {
		OP_MUL,
		OP_DIV,
		OP_SQRT
	} arith_op_t;

	typedef enum logic [13:0] {
		ST_W    = 14'b00000000000001,
		ST_SQX  = 14'b00000000000010,
		ST_SQY  = 14'b00000000000100,
		ST_SQRT = 14'b00000000001000,
		ST_RE   = 14'b00000000010000,
		ST_CW   = 14'b00000000100000,
		ST_E1   = 14'b00000001000000,
		ST_E2   = 14'b00000010000000,
		ST_DT   = 14'b00000100000000,
		ST_S    = 14'b00001000000000,
		ST_UX   = 14'b00010000000000,
		ST_MX   = 14'b00100000000000,
		ST_UY   = 14'b01000000000000,
		ST_MY   = 14'b10000000000000
	} step_t;

	typedef struct packed {
		logic               func;
		logic [23:0]        rtt_ticks;
		logic signed [39:0] remote_x;
		logic signed [39:0] remote_y;
		logic [23:0]        remote_error;
	} req_item_t;

	typedef struct packed {
		logic signed [39:0] coord_x;
		logic signed [39:0] coord_y;
		logic [23:0]        error_estimate;
		logic               converged;
		logic [1:0]         status;
	} rsp_item_t;

	typedef struct packed {
		logic [16:0]        error_gain;
		logic [16:0]        move_fraction;
		logic [23:0]        tolerance;
		logic [23:0]        default_error;
		logic signed [39:0] start_x;
		logic signed [39:0] start_y;
	} cfg_t;

	typedef struct packed {
		logic        start;
		arith_op_t   op;
		logic [5:0]  k;
		logic [81:0] a;
		logic [42:0] b;
	} arith_req_t;

	typedef struct packed {
		logic        done;
		logic        ovf;
		logic [81:0] res;
	} arith_rsp_t;

	typedef struct packed {
		logic  load;
		logic  start;
		logic  capture;
		logic  emit;
		step_t step;
	} ctrl_cmd_t;

	typedef struct packed {
		logic func;
		logic rtt_zero;
		logic dist_zero;
		logic done;
	} dp_sts_t;

endpackage

/* hdl/ncu_arith.sv */
// ----------------------------------------------------------------------------
// ncu_arith
// Shared bit-serial unit: shift-add multiply, restoring divide, square root.
// ----------------------------------------------------------------------------
module ncu_arith import ncu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  arith_req_t areq,
	output arith_rsp_t arsp
);

	logic        busy_q;
	logic        done_q;
	logic        ovf_q;
	arith_op_t   op_q;
	logic [5:0]  cnt_q;
	logic [81:0] acc_q;
	logic [81:0] sh_q;
	logic [44:0] aux_q;
	logic [41:0] root_q;

	logic [81:0] mul_sum;
	logic [44:0] div_rem;
	logic        div_ge;
	logic [44:0] sq_rem;
	logic [44:0] sq_trial;
	logic        sq_ge;
	logic [61:0] num;

	assign mul_sum  = acc_q + (aux_q[0] ? sh_q : 82'd0);
	assign div_rem  = {aux_q[43:0], sh_q[61]};
	assign div_ge   = div_rem >= {2'b00, acc_q[42:0]};
	assign sq_rem   = {aux_q[42:0], sh_q[81:80]};
	assign sq_trial = {1'b0, root_q, 2'b01};
	assign sq_ge    = sq_rem >= sq_trial;
	assign num      = areq.a[61:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (areq.start) begin
				busy_q <= 1'b1;
				cnt_q  <= (areq.op == OP_SQRT) ? K_SQRT : areq.k;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (areq.start) begin
			op_q <= areq.op;
			case (areq.op)
				OP_MUL: begin
					acc_q <= '0;
					sh_q  <= areq.a;
					aux_q <= {2'b00, areq.b};
				end
				OP_DIV: begin
					acc_q <= {39'd0, areq.b};
					aux_q <= 45'(num >> areq.k);
					sh_q  <= {20'd0, 62'(num << (7'd62 - {1'b0, areq.k}))};
					ovf_q <= (num >> areq.k) >= {19'd0, areq.b};
				end
				default: begin
					sh_q   <= areq.a;
					aux_q  <= '0;
					root_q <= '0;
				end
			endcase
		end else if (busy_q) begin
			case (op_q)
				OP_MUL: begin
					acc_q <= mul_sum;
					sh_q  <= {sh_q[80:0], 1'b0};
					aux_q <= {1'b0, aux_q[44:1]};
				end
				OP_DIV: begin
					aux_q <= div_ge ? div_rem - {2'b00, acc_q[42:0]} : div_rem;
					sh_q  <= {20'd0, sh_q[60:0], div_ge};
				end
				default: begin
					aux_q  <= sq_ge ? sq_rem - sq_trial : sq_rem;
					root_q <= {root_q[40:0], sq_ge};
					sh_q   <= {sh_q[79:0], 2'b00};
				end
			endcase
		end
	end

	always_comb begin
		arsp.done = done_q;
		arsp.ovf  = ovf_q;
		case (op_q)
			OP_MUL:  arsp.res = acc_q;
			OP_DIV:  arsp.res = sh_q;
			default: arsp.res = {40'd0, root_q};
		endcase
	end

endmodule

/* hdl/ncu_dp.sv */
// ----------------------------------------------------------------------------
// ncu_dp
// Coordinate and error state, step operands and result capture.
// ----------------------------------------------------------------------------
module ncu_dp import ncu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  req_item_t req,
	input  cfg_t      cfg,
	input  ctrl_cmd_t cmd,
	output dp_sts_t   sts,
	output rsp_item_t rsp
);

	logic signed [39:0] local_x_q;
	logic signed [39:0] local_y_q;
	logic [23:0]        local_err_q;

	logic [23:0] rtt_q;
	logic [23:0] ej_q;
	logic [40:0] absdx_q;
	logic [40:0] absdy_q;
	logic        dxneg_q;
	logic        dyneg_q;
	logic [1:0]  status_q;
	logic [16:0] w_q;
	logic [81:0] sq_q;
	logic [41:0] dist_q;
	logic [23:0] re_q;
	logic [16:0] cw_q;
	logic [40:0] t_q;
	logic [16:0] dt_q;
	logic [42:0] s_q;
	logic [20:0] u_q;
	rsp_item_t   rsp_q;

	arith_req_t areq;
	arith_rsp_t arsp;

	logic signed [40:0] dx;
	logic signed [40:0] dy;
	logic [24:0]        esum;
	logic [39:0]        rttq;
	logic               neg_s;
	logic [41:0]        diff;
	logic [16:0]        gain_eff;
	logic [16:0]        frac_eff;
	logic [41:0]        ne_sum;
	logic [43:0]        move;

	ncu_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.areq   (areq),
		.arsp   (arsp)
	);

	function automatic logic signed [39:0] step_axis(
		input logic signed [39:0] pos,
		input logic [43:0]        m,
		input logic               neg
	);
		logic signed [45:0] p;
		logic signed [45:0] r;
		p = {{6{pos[39]}}, pos};
		r = neg ? p - $signed({2'b00, m}) : p + $signed({2'b00, m});
		if (r[45:39] != {7{r[45]}}) begin
			step_axis = r[45] ? COORD_MIN : COORD_MAX;
		end else begin
			step_axis = r[39:0];
		end
	endfunction

	assign dx       = {local_x_q[39], local_x_q} - {req.remote_x[39], req.remote_x};
	assign dy       = {local_y_q[39], local_y_q} - {req.remote_y[39], req.remote_y};
	assign esum     = {1'b0, local_err_q} + {1'b0, ej_q};
	assign rttq     = {rtt_q, 16'd0};
	assign neg_s    = dist_q > {2'b00, rttq};
	assign diff     = neg_s ? dist_q - {2'b00, rttq} : {2'b00, rttq} - dist_q;
	assign gain_eff = (cfg.error_gain > ONE_Q16) ? ONE_Q16 : cfg.error_gain;
	assign frac_eff = (cfg.move_fraction > ONE_Q16) ? ONE_Q16 : cfg.move_fraction;
	assign ne_sum   = {1'b0, t_q} + {1'b0, arsp.res[40:0]};
	assign move     = arsp.res[63:20];

	always_comb begin
		areq.start = cmd.start;
		areq.op    = OP_MUL;
		areq.k     = K_Q16;
		areq.a     = '0;
		areq.b     = '0;
		unique case (cmd.step)
			ST_W: begin
				areq.op = OP_DIV;
				areq.a  = {42'd0, local_err_q, 16'd0};
				areq.b  = {18'd0, esum};
			end
			ST_SQX: begin
				areq.k = K_SQRT;
				areq.a = {41'd0, absdx_q};
				areq.b = {2'b00, absdx_q};
			end
			ST_SQY: begin
				areq.k = K_SQRT;
				areq.a = {41'd0, absdy_q};
				areq.b = {2'b00, absdy_q};
			end
			ST_SQRT: begin
				areq.op = OP_SQRT;
				areq.a  = sq_q;
			end
			ST_RE: begin
				areq.op = OP_DIV;
				areq.k  = K_RE;
				areq.a  = {40'd0, diff};
				areq.b  = {19'd0, rtt_q};
			end
			ST_CW: begin
				areq.a = {65'd0, gain_eff};
				areq.b = {26'd0, w_q};
			end
			ST_E1: begin
				areq.a = {58'd0, re_q};
				areq.b = {26'd0, cw_q};
			end
			ST_E2: begin
				areq.a = {58'd0, local_err_q};
				areq.b = {26'd0, ONE_Q16 - cw_q};
			end
			ST_DT: begin
				areq.a = {65'd0, frac_eff};
				areq.b = {26'd0, w_q};
			end
			ST_S: begin
				areq.a = {40'd0, diff};
				areq.b = {26'd0, dt_q};
			end
			ST_UX: begin
				areq.op = OP_DIV;
				areq.k  = K_UNIT;
				areq.a  = {21'd0, absdx_q, 20'd0};
				areq.b  = {1'b0, dist_q};
			end
			ST_UY: begin
				areq.op = OP_DIV;
				areq.k  = K_UNIT;
				areq.a  = {21'd0, absdy_q, 20'd0};
				areq.b  = {1'b0, dist_q};
			end
			ST_MX, ST_MY: begin
				areq.k = K_UNIT;
				areq.a = {39'd0, s_q};
				areq.b = {22'd0, u_q};
			end
			default: begin
				areq.a = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_x_q   <= '0;
			local_y_q   <= '0;
			local_err_q <= 24'd65536;
		end else if (cmd.load && req.func) begin
			local_x_q   <= cfg.start_x;
			local_y_q   <= cfg.start_y;
			local_err_q <= cfg.default_error;
		end else if (cmd.capture) begin
			case (cmd.step)
				ST_E2: local_err_q <= (|ne_sum[41:40]) ? 24'hFFFFFF : ne_sum[39:16];
				ST_MX: local_x_q <= step_axis(local_x_q, move, dxneg_q != neg_s);
				ST_MY: local_y_q <= step_axis(local_y_q, move, dyneg_q != neg_s);
				default: local_err_q <= local_err_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rtt_q   <= req.rtt_ticks;
			ej_q    <= req.remote_error;
			dxneg_q <= dx[40];
			dyneg_q <= dy[40];
			absdx_q <= dx[40] ? 41'(-dx) : 41'(dx);
			absdy_q <= dy[40] ? 41'(-dy) : 41'(dy);
			if (req.func) begin
				status_q <= STS_RESTART;
			end else if (req.rtt_ticks == '0) begin
				status_q <= STS_REJECT;
			end else begin
				status_q <= STS_UPDATED;
			end
		end
		if (cmd.capture) begin
			case (cmd.step)
				ST_W:    w_q <= (esum == '0) ? 17'd0 : arsp.res[16:0];
				ST_SQX:  sq_q <= arsp.res;
				ST_SQY:  sq_q <= sq_q + arsp.res;
				ST_SQRT: dist_q <= arsp.res[41:0];
				ST_RE:   re_q <= arsp.ovf ? 24'hFFFFFF : arsp.res[23:0];
				ST_CW:   cw_q <= arsp.res[32:16];
				ST_E1:   t_q <= arsp.res[40:0];
				ST_DT:   dt_q <= arsp.res[32:16];
				ST_S:    s_q <= arsp.res[58:16];
				ST_UX, ST_UY: u_q <= arsp.res[20:0];
				default: t_q <= t_q;
			endcase
		end
		if (cmd.emit) begin
			rsp_q.coord_x        <= local_x_q;
			rsp_q.coord_y        <= local_y_q;
			rsp_q.error_estimate <= local_err_q;
			rsp_q.converged      <= local_err_q < cfg.tolerance;
			rsp_q.status         <= status_q;
		end
	end

	assign sts.func      = req.func;
	assign sts.rtt_zero  = req.rtt_ticks == '0;
	assign sts.dist_zero = dist_q == '0;
	assign sts.done      = arsp.done;
	assign rsp           = rsp_q;

endmodule

/* hdl/ncu_ctrl.sv */
// ----------------------------------------------------------------------------
// ncu_ctrl
// Sequencer: request intake, step order of the update, result handoff.
// ----------------------------------------------------------------------------
module ncu_ctrl import ncu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	input  dp_sts_t   sts,
	output ctrl_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_CALC   = 3'b010,
		S_FINISH = 3'b100
	} state_t;

	state_t state_q;
	state_t state_n;
	step_t  step_q;
	step_t  step_n;
	logic   pend_q;
	logic   pend_n;
	logic   rsp_valid_q;

	function automatic step_t next_step(input step_t s);
		unique case (s)
			ST_W:    next_step = ST_SQX;
			ST_SQX:  next_step = ST_SQY;
			ST_SQY:  next_step = ST_SQRT;
			ST_SQRT: next_step = ST_RE;
			ST_RE:   next_step = ST_CW;
			ST_CW:   next_step = ST_E1;
			ST_E1:   next_step = ST_E2;
			ST_E2:   next_step = ST_DT;
			ST_DT:   next_step = ST_S;
			ST_S:    next_step = ST_UX;
			ST_UX:   next_step = ST_MX;
			ST_MX:   next_step = ST_UY;
			ST_UY:   next_step = ST_MY;
			default: next_step = ST_W;
		endcase
	endfunction

	always_comb begin
		state_n     = state_q;
		step_n      = step_q;
		pend_n      = pend_q;
		cmd.load    = 1'b0;
		cmd.start   = 1'b0;
		cmd.capture = 1'b0;
		cmd.emit    = 1'b0;
		cmd.step    = step_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					step_n   = ST_W;
					pend_n   = 1'b0;
					state_n  = (sts.func || sts.rtt_zero) ? S_FINISH : S_CALC;
				end
			end
			S_CALC: begin
				if (!pend_q) begin
					cmd.start = 1'b1;
					pend_n    = 1'b1;
				end else if (sts.done) begin
					cmd.capture = 1'b1;
					pend_n      = 1'b0;
					if (step_q == ST_MY || (step_q == ST_E2 && sts.dist_zero)) begin
						state_n = S_FINISH;
					end else begin
						step_n = next_step(step_q);
					end
				end
			end
			S_FINISH: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.emit = 1'b1;
					state_n  = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= ST_W;
			pend_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			step_q  <= step_n;
			pend_q  <= pend_n;
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign req_ready = state_q == S_IDLE;
	assign rsp_valid = rsp_valid_q;

endmodule

/* hdl/network_coordinate_update_unit.sv */
// ----------------------------------------------------------------------------
// network_coordinate_update_unit
// 2-D network coordinate estimator with a local error, fixed-point update.
//
// Request channel (req_valid/req_ready/req): func 1 restarts the estimate
// from the start and default-error registers, func 0 applies one round-trip
// sample against a peer coordinate and error. Response channel
// (rsp_valid/rsp_ready/rsp): one item per request with the state afterwards,
// the convergence flag and a status code.
// One request is processed at a time. A restart or a zero rtt passes from
// acceptance to the finish state and then into the response register. An
// update runs its steps in turn on the bit-serial multiply/divide/root unit
// that all steps share; the move steps are skipped when the two coordinates
// coincide. The response sits in an output register: a stalled receiver
// holds it while the next request is taken and worked on; the block then
// waits to hand over its result. Reset clears the state to the origin with
// error 1.0 and loads the register defaults. The user must write registers
// over the APB port only while the block is idle, which is not enforced.
// ----------------------------------------------------------------------------
module network_coordinate_update_unit import ncu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  req_item_t   req,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output rsp_item_t   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	cfg_t      cfg_q;
	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.error_gain    <= 17'd16384;
			cfg_q.move_fraction <= 17'd16384;
			cfg_q.tolerance     <= 24'd6554;
			cfg_q.default_error <= 24'd65536;
			cfg_q.start_x       <= 40'sd65536;
			cfg_q.start_y       <= 40'sd65536;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[5:3])
				CFG_ERROR_GAIN:    cfg_q.error_gain    <= pwdata[16:0];
				CFG_MOVE_FRACTION: cfg_q.move_fraction <= pwdata[16:0];
				CFG_TOLERANCE:     cfg_q.tolerance     <= pwdata[23:0];
				CFG_DEFAULT_ERROR: cfg_q.default_error <= pwdata[23:0];
				CFG_START_X:       cfg_q.start_x       <= pwdata[39:0];
				CFG_START_Y:       cfg_q.start_y       <= pwdata[39:0];
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[5:3])
			CFG_ERROR_GAIN:    prdata = {47'd0, cfg_q.error_gain};
			CFG_MOVE_FRACTION: prdata = {47'd0, cfg_q.move_fraction};
			CFG_TOLERANCE:     prdata = {40'd0, cfg_q.tolerance};
			CFG_DEFAULT_ERROR: prdata = {40'd0, cfg_q.default_error};
			CFG_START_X:       prdata = {24'd0, cfg_q.start_x};
			CFG_START_Y:       prdata = {24'd0, cfg_q.start_y};
			default:           prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	ncu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ncu_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cfg    (cfg_q),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

/* hdl/ncu_checker.sv */
// ----------------------------------------------------------------------------
// ncu_checker
// Port-level checks of the network coordinate update unit.
// ----------------------------------------------------------------------------
module ncu_checker import ncu_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_ready,
	input req_item_t req,
	input logic      rsp_valid,
	input logic      rsp_ready,
	input rsp_item_t rsp
);

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in flight");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.func && !rsp_valid
		|-> ##2 (rsp_valid && rsp.status == STS_RESTART))
		else $error("restart response missing");

	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && !req.func && req.rtt_ticks == '0 && !rsp_valid
		|-> ##2 (rsp_valid && rsp.status == STS_REJECT))
		else $error("zero rtt response missing");

endmodule

bind network_coordinate_update_unit ncu_checker u_ncu_checker (.*);
